// ===== rtl/core/ust_pkg.sv =====
// Shared types and constants for the unordered set table.
// Holds the request codes, controller states and the command/status structs.
// No dependencies.
package ust_pkg;

   localparam int unsigned DEF_CAPACITY = 64;
   localparam int unsigned VALUE_W      = 32;
   localparam int unsigned COUNT_OUT_W  = 7;

   typedef enum logic [1:0] {
      REQ_LOOKUP = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_REMOVE = 2'd2,
      REQ_CLEAR  = 2'd3
   } ust_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUTE,
      ST_SCAN,
      ST_DECIDE,
      ST_MOVE,
      ST_FINISH
   } ust_state_type;

   typedef struct packed {
      logic load_req;
      logic clear_cnt;
      logic scan_run;
      logic ins_write;
      logic rej_set;
      logic last_read;
      logic move_write;
      logic rsp_load;
   } ust_cmd_type;

   typedef struct packed {
      ust_req_type req_kind;
      logic        cnt_zero;
      logic        cnt_full;
      logic        scan_done;
      logic        found;
      logic        rsp_free;
   } ust_status_type;

endpackage

// ===== rtl/core/ust_req_if.sv =====
// Request channel interface: valid/ready handshake with request kind and value.
// Depends on ust_pkg.
interface ust_req_if;
   import ust_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [1:0]                req_type;
   logic signed [VALUE_W-1:0] elem_value;

   modport source (output valid, output req_type, output elem_value, input ready);
   modport sink   (input valid, input req_type, input elem_value, output ready);

endinterface

// ===== rtl/core/ust_rsp_if.sv =====
// Response channel interface: valid/ready handshake with the result fields.
// Depends on ust_pkg.
interface ust_rsp_if;
   import ust_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   was_present;
   logic                   rejected_full;
   logic [COUNT_OUT_W-1:0] element_count;
   logic                   set_empty;

   modport source (output valid, output was_present, output rejected_full,
                   output element_count, output set_empty, input ready);
   modport sink   (input valid, input was_present, input rejected_full,
                   input element_count, input set_empty, output ready);

endinterface

// ===== rtl/core/unordered_set_table.sv =====
// A set of up to CAPACITY distinct signed 32-bit values, stored packed and
// unordered in a single-port-read RAM. Each request (lookup, insert, remove or
// clear) yields exactly one response. The scan reads one RAM entry per cycle,
// at most one for each stored element, and stops at the first match; a remove
// that hits then fetches the last entry before it is moved into the freed
// slot. A clear skips the scan. The response sits in an output register, so
// the block is ready for its next request while the previous response waits
// to be taken.
// Depends on ust_pkg, ust_req_if, ust_rsp_if, ust_ram, ust_ctrl and ust_dpath.
module unordered_set_table #(
   parameter int unsigned CAPACITY = ust_pkg::DEF_CAPACITY
) (
   input logic         clock,
   input logic         reset,
   ust_req_if.sink     req_chan,
   ust_rsp_if.source   rsp_chan
);
   import ust_pkg::*;

   ust_cmd_type    cmd;
   ust_status_type status;

   ust_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ust_dpath #(.CAPACITY(CAPACITY)) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_type      (req_chan.req_type),
      .elem_value    (req_chan.elem_value),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .was_present   (rsp_chan.was_present),
      .rejected_full (rsp_chan.rejected_full),
      .element_count (rsp_chan.element_count),
      .set_empty     (rsp_chan.set_empty)
   );

   // A refused insert means the value was absent and the set was full.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.rejected_full) |->
         (!rsp_chan.was_present && rsp_chan.element_count == COUNT_OUT_W'(CAPACITY)))
      else $error("rejected insert without a full set");

   // An append never happens into a full set.
   assert property (@(posedge clock) disable iff (reset)
      cmd.ins_write |-> !status.cnt_full)
      else $error("insert write while the set is full");

   // Moving the last entry always follows its read in the previous cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.move_write |-> $past(cmd.last_read))
      else $error("move write without a preceding read of the last entry");

endmodule

// ===== rtl/core/ust_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ust_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ust_ctrl.sv =====
// Controller state machine for the unordered set table.
// Sequences route, scan, update and response steps. Depends on ust_pkg.
module ust_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ust_pkg::ust_status_type status,
   output ust_pkg::ust_cmd_type    cmd
);
   import ust_pkg::*;

   ust_state_type state_ff;
   ust_state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_ROUTE;
         end
         ST_ROUTE: begin
            if (status.req_kind == REQ_CLEAR) state_in = ST_FINISH;
            else if (status.cnt_zero)         state_in = ST_DECIDE;
            else                              state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_done) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.req_kind == REQ_REMOVE && status.found) state_in = ST_MOVE;
            else                                                state_in = ST_FINISH;
         end
         ST_MOVE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ST_ROUTE: begin
            cmd.clear_cnt = (status.req_kind == REQ_CLEAR);
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
         end
         ST_DECIDE: begin
            cmd.ins_write = (status.req_kind == REQ_INSERT) && !status.found
                            && !status.cnt_full;
            cmd.rej_set   = (status.req_kind == REQ_INSERT) && !status.found
                            && status.cnt_full;
            cmd.last_read = (status.req_kind == REQ_REMOVE) && status.found;
         end
         ST_MOVE: begin
            cmd.move_write = 1'b1;
         end
         ST_FINISH: begin
            cmd.rsp_load = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/ust_dpath.sv =====
// Datapath for the unordered set table: element RAM, count, scan pointers
// and the response register. Depends on ust_pkg and ust_ram.
module ust_dpath #(
   parameter int unsigned CAPACITY = ust_pkg::DEF_CAPACITY
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [1:0]                          req_type,
   input  logic signed [ust_pkg::VALUE_W-1:0]  elem_value,
   input  ust_pkg::ust_cmd_type                cmd,
   output ust_pkg::ust_status_type             status,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                was_present,
   output logic                                rejected_full,
   output logic [ust_pkg::COUNT_OUT_W-1:0]     element_count,
   output logic                                set_empty
);
   import ust_pkg::*;

   localparam int unsigned ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

   ust_req_type         type_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    scan_idx_ff, scan_idx_in;
   logic [ADDR_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic                cmp_valid_ff;
   logic                found_ff, found_in;
   logic                rej_ff, rej_in;
   logic [ADDR_W-1:0]   pos_ff, pos_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                present_ff, rejected_ff, empty_ff;
   logic [COUNT_OUT_W-1:0] count_out_ff;

   logic                issue;
   logic [CNT_W-1:0]    last_idx;
   logic                match;
   logic                scan_last;
   logic                rd_en, wr_en;
   logic [ADDR_W-1:0]   rd_addr, wr_addr;
   logic [VALUE_W-1:0]  wr_data, rd_data;

   ust_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Reads are issued one per cycle; each compare sees the data of the
   // read issued in the previous cycle.
   always_comb begin
      last_idx  = count_ff - CNT_W'(1);
      issue     = cmd.scan_run && (scan_idx_ff < count_ff);
      rd_en     = issue || cmd.last_read;
      rd_addr   = cmd.last_read ? ADDR_W'(last_idx) : ADDR_W'(scan_idx_ff);
      wr_en     = cmd.ins_write || cmd.move_write;
      wr_addr   = cmd.move_write ? pos_ff : ADDR_W'(count_ff);
      wr_data   = cmd.move_write ? rd_data : value_ff;
      match     = cmp_valid_ff && (rd_data == value_ff);
      scan_last = cmp_valid_ff && (CNT_W'(cmp_idx_ff) == last_idx);
   end

   always_comb begin
      scan_idx_in = scan_idx_ff;
      cmp_idx_in  = cmp_idx_ff;
      found_in    = found_ff;
      rej_in      = rej_ff;
      pos_in      = pos_ff;
      count_in    = count_ff;
      if (cmd.load_req) begin
         scan_idx_in = '0;
         found_in    = 1'b0;
         rej_in      = 1'b0;
      end
      if (issue) begin
         scan_idx_in = scan_idx_ff + CNT_W'(1);
         cmp_idx_in  = ADDR_W'(scan_idx_ff);
      end
      if (cmd.scan_run && match) begin
         found_in = 1'b1;
         pos_in   = cmp_idx_ff;
      end
      if (cmd.rej_set) begin
         rej_in = 1'b1;
      end
      if (cmd.clear_cnt) begin
         count_in = '0;
      end else if (cmd.ins_write) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.move_write) begin
         count_in = last_idx;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cmp_valid_ff <= issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         type_ff  <= ust_req_type'(req_type);
         value_ff <= elem_value;
      end
      scan_idx_ff <= scan_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      found_ff    <= found_in;
      rej_ff      <= rej_in;
      pos_ff      <= pos_in;
      if (cmd.rsp_load) begin
         present_ff   <= found_ff;
         rejected_ff  <= rej_ff;
         count_out_ff <= COUNT_OUT_W'(count_ff);
         empty_ff     <= (count_ff == '0);
      end
   end

   always_comb begin
      status.req_kind  = type_ff;
      status.cnt_zero  = (count_ff == '0);
      status.cnt_full  = (count_ff == CNT_W'(CAPACITY));
      status.scan_done = match || scan_last;
      status.found     = found_ff;
      status.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign was_present   = present_ff;
   assign rejected_full = rejected_ff;
   assign element_count = count_out_ff;
   assign set_empty     = empty_ff;

endmodule

// ===== tb/tb_unordered_set_table.sv =====
// Self-checking testbench for the unordered set table: drives lookup, insert,
// remove and clear requests and checks every response against a shadow set.
// Depends on ust_pkg, ust_req_if, ust_rsp_if and the unordered_set_table RTL.
module tb_unordered_set_table;
   timeunit 1ns;
   timeprecision 1ps;

   import ust_pkg::*;

   localparam int unsigned SET_CAPACITY = DEF_CAPACITY;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned DRAIN_CYCLES = SET_CAPACITY + 16;

   typedef logic signed [VALUE_W-1:0] set_value_type;

   typedef struct packed {
      logic                   was_present;
      logic                   rejected_full;
      logic [COUNT_OUT_W-1:0] element_count;
      logic                   set_empty;
   } set_result_type;

   logic clock;
   logic reset;

   ust_req_if req_if ();
   ust_rsp_if rsp_if ();

   unordered_set_table #(.CAPACITY(SET_CAPACITY)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   // Shadow copy of the set, updated when a request transaction is accepted.
   set_value_type set_shadow [SET_CAPACITY];
   int unsigned   shadow_count;
   int unsigned   peak_count;

   set_result_type expected_results[$];

   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned requests_sent;
   int unsigned results_checked;
   int unsigned rejects_seen;
   int unsigned error_count;
   int unsigned cycle_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Returns the slot holding the value, or shadow_count when it is absent.
   function automatic int unsigned shadow_position(set_value_type value);
      for (int unsigned i = 0; i < shadow_count; i++) begin
         if (set_shadow[i] == value) return i;
      end
      return shadow_count;
   endfunction

   function automatic set_result_type predict_set_update(ust_req_type kind,
                                                         set_value_type value);
      set_result_type result;
      int unsigned    pos;
      logic           hit;
      result = '0;
      hit    = 1'b0;
      if (kind == REQ_CLEAR) begin
         shadow_count = 0;
      end else begin
         pos = shadow_position(value);
         hit = (pos < shadow_count);
         case (kind)
            REQ_INSERT: begin
               if (!hit) begin
                  if (shadow_count < SET_CAPACITY) begin
                     set_shadow[shadow_count] = value;
                     shadow_count++;
                  end else begin
                     result.rejected_full = 1'b1;
                  end
               end
            end
            REQ_REMOVE: begin
               // The last entry fills the hole left by the removed one.
               if (hit) begin
                  set_shadow[pos] = set_shadow[shadow_count - 1];
                  shadow_count--;
               end
            end
            default: ;
         endcase
      end
      if (shadow_count > peak_count) peak_count = shadow_count;
      result.was_present   = hit;
      result.element_count = shadow_count[COUNT_OUT_W-1:0];
      result.set_empty     = (shadow_count == 0);
      return result;
   endfunction

   // Half the operands come from the set (narrow range if empty), a quarter from
   // a narrow range so that collisions are common, the rest from the full 32-bit range.
   function automatic set_value_type pick_operand();
      int unsigned roll;
      roll = $urandom_range(99);
      if (shadow_count != 0 && roll < 50) return set_shadow[$urandom_range(shadow_count - 1)];
      if (roll < 75) return $signed($urandom_range(31)) - 16;
      return set_value_type'($urandom);
   endfunction

   task automatic send_request(ust_req_type kind, set_value_type value);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_if.valid      <= 1'b1;
      req_if.req_type   <= kind;
      req_if.elem_value <= value;
      do @(posedge clock); while (!req_if.ready);
      expected_results.insert(expected_results.size(), predict_set_update(kind, value));
      requests_sent++;
   endtask

   always @(posedge clock) begin
      set_result_type exp;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_checked++;
            if (rsp_if.rejected_full) rejects_seen++;
            if (expected_results.size() == 0) begin
               $error("response transaction with no request outstanding");
               error_count++;
            end else begin
               exp = expected_results.pop_front();
               if (rsp_if.was_present !== exp.was_present) begin
                  $error("was_present: expected %0d, got %0d", exp.was_present,
                         rsp_if.was_present);
                  error_count++;
               end
               if (rsp_if.rejected_full !== exp.rejected_full) begin
                  $error("rejected_full: expected %0d, got %0d", exp.rejected_full,
                         rsp_if.rejected_full);
                  error_count++;
               end
               if (rsp_if.element_count !== exp.element_count) begin
                  $error("element_count: expected %0d, got %0d", exp.element_count,
                         rsp_if.element_count);
                  error_count++;
               end
               if (rsp_if.set_empty !== exp.set_empty) begin
                  $error("set_empty: expected %0d, got %0d", exp.set_empty,
                         rsp_if.set_empty);
                  error_count++;
               end
            end
         end
         rsp_if.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out with %0d responses still outstanding.",
                  expected_results.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Extreme values, duplicates, removal from the middle, front and back of the
   // packed array, and a clear whose operand matches a stored value.
   task automatic test_directed_corners();
      send_request(REQ_LOOKUP, 0);
      send_request(REQ_REMOVE, 5);
      send_request(REQ_CLEAR,  32'sh7FFF_FFFF);
      send_request(REQ_INSERT, 32'sh8000_0000);
      send_request(REQ_INSERT, 32'sh7FFF_FFFF);
      send_request(REQ_INSERT, 0);
      send_request(REQ_INSERT, -1);
      send_request(REQ_INSERT, 32'sh8000_0000);
      send_request(REQ_LOOKUP, 32'sh7FFF_FFFF);
      send_request(REQ_LOOKUP, 1);
      send_request(REQ_REMOVE, 32'sh7FFF_FFFF);
      send_request(REQ_LOOKUP, 32'sh7FFF_FFFF);
      send_request(REQ_LOOKUP, -1);
      send_request(REQ_REMOVE, -1);
      send_request(REQ_REMOVE, 32'sh8000_0000);
      send_request(REQ_REMOVE, 0);
      send_request(REQ_REMOVE, 0);
      send_request(REQ_INSERT, 32'sh5555_5555);
      send_request(REQ_INSERT, 32'shAAAA_AAAA);
      send_request(REQ_CLEAR,  32'sh5555_5555);
      send_request(REQ_LOOKUP, 32'sh5555_5555);
      send_request(REQ_INSERT, 1);
      send_request(REQ_REMOVE, 1);
   endtask

   task automatic test_random_mix(int unsigned count);
      int unsigned roll;
      for (int unsigned n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 40)      send_request(REQ_INSERT, pick_operand());
         else if (roll < 65) send_request(REQ_LOOKUP, pick_operand());
         else if (roll < 97) send_request(REQ_REMOVE, pick_operand());
         else                send_request(REQ_CLEAR, set_value_type'($urandom));
      end
   endtask

   // Fills the set to capacity with random distinct values, probes the full
   // set, then drains it in random order.
   task automatic test_fill_and_drain();
      set_value_type members[$];
      set_value_type value;
      int unsigned   idx;
      send_request(REQ_CLEAR, set_value_type'($urandom));
      while (shadow_count < SET_CAPACITY) begin
         value = set_value_type'($urandom);
         if (shadow_position(value) == shadow_count) begin
            send_request(REQ_INSERT, value);
            members.insert(members.size(), value);
         end
      end
      for (int unsigned n = 0; n < 8; n++) begin
         do value = set_value_type'($urandom); while (shadow_position(value) != shadow_count);
         send_request(REQ_INSERT, value);
         send_request(REQ_LOOKUP, members[$urandom_range(members.size() - 1)]);
      end
      send_request(REQ_INSERT, members[0]);
      send_request(REQ_INSERT, members[SET_CAPACITY - 1]);
      send_request(REQ_LOOKUP, members[SET_CAPACITY - 1]);
      while (members.size() != 0) begin
         idx   = $urandom_range(members.size() - 1);
         value = members[idx];
         members.delete(idx);
         send_request(REQ_REMOVE, value);
         if ($urandom_range(7) == 0) send_request(REQ_REMOVE, value);
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.req_type   = REQ_LOOKUP;
      req_if.elem_value = '0;
      shadow_count      = 0;
      peak_count        = 0;
      send_idle_pct     = 0;
      recv_stall_pct    = 0;
      requests_sent     = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed_corners();

      test_random_mix(200);
      test_fill_and_drain();

      send_idle_pct = 74;
      test_random_mix(200);

      send_idle_pct  = 0;
      recv_stall_pct <= 74;
      test_random_mix(200);

      send_idle_pct  = 7;
      recv_stall_pct <= 7;
      test_random_mix(200);
      test_fill_and_drain();

      req_if.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d responses to %0d requests; peak occupancy %0d of %0d,",
               results_checked, requests_sent, peak_count, SET_CAPACITY);
      $display("%0d full-set rejections, under four sender/receiver pacing modes.",
               rejects_seen);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
